// ----- rtl/gra_pkg.sv -----
// shared constants, codes and control types of the grid rectangle allocator
package gra_pkg;

	localparam int ENTRIES     = 32;
	localparam int ENTRY_BITS  = 5;
	localparam int SIDE_MAX    = 16;
	localparam int SIDE_BITS   = 5;
	localparam int X_BITS      = 4;
	localparam int Y_BITS      = 8;
	localparam int CORNER_BITS = 8;
	localparam int CELL_BITS   = 9;
	localparam int IDENT_BITS  = 16;
	localparam int SIZE_BITS   = 5;
	localparam int DIV_STEPS   = 8;
	localparam int DIV_CNT_BITS = 3;

	localparam logic [IDENT_BITS-1:0] IDENT_TOP   = {IDENT_BITS{1'b1}};
	localparam logic [SIDE_BITS-1:0]  SIDE_RESET  = 5'd8;
	localparam logic [SIDE_BITS-1:0]  SIDE_LIMIT  = 5'd16;

	// opcodes
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_MOVE   = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_CHECK  = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
	localparam logic [2:0] ST_EXHAUSTED = 3'd2;
	localparam logic [2:0] ST_NO_SPACE  = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_BAD_PLACE = 3'd5;

	// register indexes
	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic       req_load;
		logic       ctr_clear;
		logic       ctr_step;
		logic       walk_latch;
		logic       dirty_clear;
		logic       div_start;
		logic       div_step;
		logic       sel_scan;
		logic       commit_add;
		logic       commit_move;
		logic       commit_remove;
		logic       res_load;
		logic       res_ok;
		logic       res_add;
		logic [2:0] res_status;
		logic       out_load;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic       dirty;
		logic [1:0] op;
		logic       walk_last;
		logic       div_last;
		logic       size_zero;
		logic       exhausted;
		logic       table_full;
		logic       hit;
		logic       fit;
		logic       scan_end;
		logic       out_free;
	} sts_t;

endpackage

// ----- rtl/gra_ctrl.sv -----
// sequencing state machine of the grid rectangle allocator
module gra_ctrl import gra_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_WALK   = 3'd1;
	localparam logic [2:0] S_PREP   = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_DIV    = 3'd4;
	localparam logic [2:0] S_FIT    = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.req_load = 1'b1;
					cmd.ctr_clear = 1'b1;
					state_d = sts.dirty ? S_WALK : S_PREP;
				end
			end
			S_WALK: begin
				cmd.walk_latch = 1'b1;
				cmd.ctr_step = 1'b1;
				if (sts.walk_last) begin
					cmd.dirty_clear = 1'b1;
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.ctr_clear = 1'b1;
				state_d = S_FINISH;
				unique case (sts.op)
					OP_ADD: begin
						if (sts.size_zero) begin
							cmd.res_load = 1'b1;
							cmd.res_status = ST_BAD_SIZE;
						end else if (sts.exhausted) begin
							cmd.res_load = 1'b1;
							cmd.res_status = ST_EXHAUSTED;
						end else if (sts.table_full) begin
							cmd.res_load = 1'b1;
							cmd.res_status = ST_NO_SPACE;
						end else begin
							state_d = S_SCAN;
						end
					end
					OP_MOVE: begin
						if (!sts.hit) begin
							cmd.res_load = 1'b1;
							cmd.res_status = ST_NOT_FOUND;
						end else begin
							cmd.div_start = 1'b1;
							state_d = S_DIV;
						end
					end
					OP_REMOVE: begin
						cmd.res_load = 1'b1;
						if (!sts.hit) begin
							cmd.res_status = ST_NOT_FOUND;
						end else begin
							cmd.commit_remove = 1'b1;
							cmd.res_ok = 1'b1;
							cmd.res_status = ST_OK;
						end
					end
					default: begin
						if (sts.size_zero) begin
							cmd.res_load = 1'b1;
							cmd.res_status = ST_BAD_SIZE;
						end else begin
							cmd.div_start = 1'b1;
							state_d = S_DIV;
						end
					end
				endcase
			end
			S_SCAN: begin
				cmd.sel_scan = 1'b1;
				if (sts.scan_end) begin
					cmd.res_load = 1'b1;
					cmd.res_status = ST_NO_SPACE;
					state_d = S_FINISH;
				end else if (sts.fit) begin
					cmd.commit_add = 1'b1;
					cmd.res_load = 1'b1;
					cmd.res_ok = 1'b1;
					cmd.res_add = 1'b1;
					cmd.res_status = ST_OK;
					state_d = S_FINISH;
				end else begin
					cmd.ctr_step = 1'b1;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_FIT;
				end
			end
			S_FIT: begin
				cmd.res_load = 1'b1;
				state_d = S_FINISH;
				if (sts.fit) begin
					cmd.res_ok = 1'b1;
					cmd.res_status = ST_OK;
					cmd.commit_move = (sts.op == OP_MOVE);
				end else begin
					cmd.res_status = ST_BAD_PLACE;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/gra_dp.sv -----
// datapath: item table, grid registers, counters, divider, overlap test, result
module gra_dp import gra_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	input  logic [1:0]             in_op,
	input  logic [IDENT_BITS-1:0]  in_ident,
	input  logic [SIZE_BITS-1:0]   in_width,
	input  logic [SIZE_BITS-1:0]   in_height,
	input  logic [CORNER_BITS-1:0] in_corner,
	input  logic                   in_rotate,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [SIDE_BITS-1:0]   cfg_value,
	output logic [SIDE_BITS-1:0]   cfg_rdata_cols,
	output logic [SIDE_BITS-1:0]   cfg_rdata_rows,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   out_accepted,
	output logic [2:0]             out_status,
	output logic [IDENT_BITS-1:0]  out_ident,
	output logic [CORNER_BITS-1:0] out_placed
);

	// grid registers
	logic [SIDE_BITS-1:0] cols_q, rows_q;
	logic                 dirty_q;
	logic [SIDE_BITS-1:0] clamped;
	logic [9:0]           cells_full;
	logic [CELL_BITS-1:0] cells;

	// request
	logic [1:0]             op_q;
	logic [IDENT_BITS-1:0]  ident_q;
	logic [SIZE_BITS-1:0]   rw_q, rh_q;
	logic [CORNER_BITS-1:0] corner_q;
	logic                   rot_q;

	// item table
	logic [ENTRIES-1:0]     ent_valid_q;
	logic [IDENT_BITS-1:0]  ent_ident_q  [ENTRIES];
	logic [CORNER_BITS-1:0] ent_corner_q [ENTRIES];
	logic [SIZE_BITS-1:0]   ent_w_q      [ENTRIES];
	logic [SIZE_BITS-1:0]   ent_h_q      [ENTRIES];
	logic                   ent_rot_q    [ENTRIES];
	logic [X_BITS-1:0]      ent_tx_q     [ENTRIES];
	logic [Y_BITS-1:0]      ent_ty_q     [ENTRIES];
	logic [IDENT_BITS-1:0]  next_ident_q;

	// cell counters and divider
	logic [X_BITS-1:0]       x_q;
	logic [Y_BITS-1:0]       y_q;
	logic [CELL_BITS-1:0]    c_q;
	logic [CORNER_BITS-1:0]  dvd_q, quot_q;
	logic [SIDE_BITS-1:0]    rem_q;
	logic [DIV_CNT_BITS-1:0] div_cnt_q;
	logic [SIDE_BITS:0]      div_trial;
	logic                    div_ge;

	// result and output
	logic                   res_ok_q;
	logic [2:0]             res_status_q;
	logic [IDENT_BITS-1:0]  res_ident_q;
	logic [CORNER_BITS-1:0] res_placed_q;
	logic                   out_valid_q;

	// searches and overlap
	logic                   hit;
	logic [ENTRY_BITS-1:0]  hit_idx;
	logic                   free_any;
	logic [ENTRY_BITS-1:0]  free_idx;
	logic                   next_used;
	logic [X_BITS-1:0]      cand_x;
	logic [Y_BITS-1:0]      cand_y;
	logic [CELL_BITS-1:0]   cand_c;
	logic [SIZE_BITS-1:0]   cand_w, cand_h;
	logic [IDENT_BITS-1:0]  skip_ident;
	logic                   in_bounds;
	logic [ENTRIES-1:0]     lane_hit;
	logic [SIZE_BITS-1:0]   ew, eh;
	logic [SIZE_BITS:0]     ex_end, cx_end;
	logic [Y_BITS:0]        ey_end, cy_end;

	assign cells_full = cols_q * rows_q;
	assign cells = cells_full[CELL_BITS-1:0];
	assign cfg_rdata_cols = cols_q;
	assign cfg_rdata_rows = rows_q;

	// clamp written side to its legal range
	always_comb begin
		if (cfg_value == '0) begin
			clamped = 5'd1;
		end else if (cfg_value > SIDE_LIMIT) begin
			clamped = SIDE_LIMIT;
		end else begin
			clamped = cfg_value;
		end
	end

	// grid registers, coordinate cache dirty flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= SIDE_RESET;
			rows_q <= SIDE_RESET;
			dirty_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_COLUMNS) begin
					cols_q <= clamped;
				end else begin
					rows_q <= clamped;
				end
				dirty_q <= 1'b1;
			end else if (cmd.dirty_clear) begin
				dirty_q <= 1'b0;
			end
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			op_q <= in_op;
			ident_q <= in_ident;
			rw_q <= in_width;
			rh_q <= in_height;
			corner_q <= in_corner;
			rot_q <= in_rotate;
		end
	end

	// table searches
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		free_any = 1'b0;
		free_idx = '0;
		next_used = 1'b0;
		for (int e = ENTRIES - 1; e >= 0; e--) begin
			if (ent_valid_q[e] && ent_ident_q[e] == ident_q && ident_q != '0) begin
				hit = 1'b1;
				hit_idx = ENTRY_BITS'(e);
			end
			if (!ent_valid_q[e]) begin
				free_any = 1'b1;
				free_idx = ENTRY_BITS'(e);
			end
			if (ent_valid_q[e] && ent_ident_q[e] == next_ident_q) begin
				next_used = 1'b1;
			end
		end
	end

	// candidate rectangle
	always_comb begin
		if (cmd.sel_scan) begin
			cand_x = x_q;
			cand_y = y_q;
			cand_c = c_q;
			cand_w = rw_q;
			cand_h = rh_q;
		end else begin
			cand_x = rem_q[X_BITS-1:0];
			cand_y = quot_q;
			cand_c = {1'b0, corner_q};
			if (op_q == OP_MOVE) begin
				cand_w = rot_q ? ent_h_q[hit_idx] : ent_w_q[hit_idx];
				cand_h = rot_q ? ent_w_q[hit_idx] : ent_h_q[hit_idx];
			end else begin
				cand_w = rot_q ? rh_q : rw_q;
				cand_h = rot_q ? rw_q : rh_q;
			end
		end
		skip_ident = (op_q == OP_ADD) ? '0 : ident_q;
		cx_end = {2'b0, cand_x} + {1'b0, cand_w};
		cy_end = {1'b0, cand_y} + {4'b0, cand_h};
		in_bounds = (cand_c < cells) && cand_w != '0 && cand_h != '0
			&& cx_end <= {1'b0, cols_q} && cy_end <= {4'b0, rows_q};
	end

	// overlap of the candidate with every other stored item
	always_comb begin
		lane_hit = '0;
		ew = '0;
		eh = '0;
		ex_end = '0;
		ey_end = '0;
		for (int e = 0; e < ENTRIES; e++) begin
			ew = ent_rot_q[e] ? ent_h_q[e] : ent_w_q[e];
			eh = ent_rot_q[e] ? ent_w_q[e] : ent_h_q[e];
			ex_end = {2'b0, ent_tx_q[e]} + {1'b0, ew};
			ey_end = {1'b0, ent_ty_q[e]} + {4'b0, eh};
			lane_hit[e] = ent_valid_q[e] && ent_ident_q[e] != skip_ident
				&& {1'b0, ent_corner_q[e]} < cells
				&& {2'b0, cand_x} < ex_end && {2'b0, ent_tx_q[e]} < cx_end
				&& {1'b0, cand_y} < ey_end && {1'b0, ent_ty_q[e]} < cy_end;
		end
	end

	// table valid bits and identifier counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= '0;
			next_ident_q <= 16'd1;
		end else begin
			if (cmd.commit_add) begin
				ent_valid_q[free_idx] <= 1'b1;
				next_ident_q <= next_ident_q + 16'd1;
			end else if (cmd.commit_remove) begin
				ent_valid_q[hit_idx] <= 1'b0;
			end
		end
	end

	// table payload and cached coordinates
	always_ff @(posedge clk) begin
		if (cmd.walk_latch) begin
			for (int e = 0; e < ENTRIES; e++) begin
				if (ent_corner_q[e] == c_q[CORNER_BITS-1:0]) begin
					ent_tx_q[e] <= x_q;
					ent_ty_q[e] <= y_q;
				end
			end
		end
		if (cmd.commit_add) begin
			ent_ident_q[free_idx] <= next_ident_q;
			ent_corner_q[free_idx] <= c_q[CORNER_BITS-1:0];
			ent_w_q[free_idx] <= rw_q;
			ent_h_q[free_idx] <= rh_q;
			ent_rot_q[free_idx] <= 1'b0;
			ent_tx_q[free_idx] <= x_q;
			ent_ty_q[free_idx] <= y_q;
		end
		if (cmd.commit_move) begin
			ent_corner_q[hit_idx] <= corner_q;
			ent_rot_q[hit_idx] <= rot_q;
			ent_tx_q[hit_idx] <= rem_q[X_BITS-1:0];
			ent_ty_q[hit_idx] <= quot_q;
		end
	end

	// row-major cell counters
	always_ff @(posedge clk) begin
		if (cmd.ctr_clear) begin
			x_q <= '0;
			y_q <= '0;
			c_q <= '0;
		end else if (cmd.ctr_step) begin
			c_q <= c_q + 9'd1;
			if ({1'b0, x_q} == cols_q - 5'd1) begin
				x_q <= '0;
				y_q <= y_q + 8'd1;
			end else begin
				x_q <= x_q + 4'd1;
			end
		end
	end

	// corner divided by column count, one quotient bit a cycle
	assign div_trial = {rem_q, dvd_q[CORNER_BITS-1]};
	assign div_ge = div_trial >= {1'b0, cols_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q <= corner_q;
			rem_q <= '0;
			quot_q <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[CORNER_BITS-2:0], 1'b0};
			rem_q <= div_ge ? SIDE_BITS'(div_trial - {1'b0, cols_q})
				: div_trial[SIDE_BITS-1:0];
			quot_q <= {quot_q[CORNER_BITS-2:0], div_ge};
			div_cnt_q <= div_cnt_q + 3'd1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_ok_q <= cmd.res_ok;
			res_status_q <= cmd.res_status;
			res_ident_q <= cmd.res_add ? next_ident_q : '0;
			res_placed_q <= cmd.res_add ? c_q[CORNER_BITS-1:0] : corner_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_accepted <= res_ok_q;
			out_status <= res_status_q;
			out_ident <= res_ident_q;
			out_placed <= res_placed_q;
		end
	end

	assign out_valid = out_valid_q;

	// status to controller
	always_comb begin
		sts.dirty = dirty_q;
		sts.op = op_q;
		sts.walk_last = (c_q[CORNER_BITS-1:0] == {CORNER_BITS{1'b1}});
		sts.div_last = (div_cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1));
		sts.size_zero = (rw_q == '0) || (rh_q == '0);
		sts.exhausted = (next_ident_q == '0) || (next_ident_q >= IDENT_TOP) || next_used;
		sts.table_full = !free_any;
		sts.hit = hit;
		sts.fit = in_bounds && (lane_hit == '0);
		sts.scan_end = (c_q >= cells);
		sts.out_free = !out_valid_q || out_ready;
	end

endmodule

// ----- rtl/grid_rectangle_allocator.sv -----
// top level of the grid rectangle allocator: stream ports, register port, wiring
//
// Request stream (s_*): one request per transaction, opcode in s_tuser.
// Result stream (m_*): exactly one result per request, in request order.
// Register port: grid_columns at byte address 0, grid_rows at 4, both read back;
// zero is written as one, values above sixteen as sixteen.
// Sequence: the first request after reset or after a register write first walks
// all 256 cell indexes to rebuild item coordinates. Then add tests candidate
// corners in turn (at most columns*rows of them), move and check pass through
// the 8-step corner divider, and remove and requests rejected up front go
// straight to the result.
// One request is in work at a time; s_tready is high only when idle.
// The result sits in an output register: a stalled receiver holds it, the next
// request is taken meanwhile and its result waits until the register frees.
// Reset empties the item table, sets the next identifier to one and the grid
// to 8 by 8.
module grid_rectangle_allocator import gra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // item_ident, rect_width, rect_height, corner_index, rotate
	input  logic [1:0]  s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // accepted, status, assigned_ident, placed_index
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cmd_t                   cmd;
	sts_t                   sts;
	logic                   cfg_we;
	logic [SIDE_BITS-1:0]   rd_cols, rd_rows;
	logic                   o_acc;
	logic [2:0]             o_status;
	logic [IDENT_BITS-1:0]  o_ident;
	logic [CORNER_BITS-1:0] o_placed;

	// register port decode
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign prdata = {27'b0, (paddr[2] == REG_ROWS) ? rd_rows : rd_cols};

	gra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gra_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_op          (s_tuser),
		.in_ident       (s_tdata[15:0]),
		.in_width       (s_tdata[20:16]),
		.in_height      (s_tdata[25:21]),
		.in_corner      (s_tdata[33:26]),
		.in_rotate      (s_tdata[34]),
		.cfg_we         (cfg_we),
		.cfg_index      (paddr[2]),
		.cfg_value      (pwdata[4:0]),
		.cfg_rdata_cols (rd_cols),
		.cfg_rdata_rows (rd_rows),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_accepted   (o_acc),
		.out_status     (o_status),
		.out_ident      (o_ident),
		.out_placed     (o_placed)
	);

	// result packing
	assign m_tdata = {4'b0, o_placed, o_ident, o_status, o_acc};

endmodule

// ----- tb/sv/grid_rectangle_allocator_test.sv -----
// testbench of the grid rectangle allocator: directed table, random requests, result checking
`timescale 1ns / 1ps

module grid_rectangle_allocator_test;
	import gra_pkg::*;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] ident;
		logic [4:0]  wid;
		logic [4:0]  hgt;
		logic [7:0]  corner;
		logic        rot;
	} request_t;

	typedef struct packed {
		logic        ok;
		logic [2:0]  status;
		logic [15:0] given;
		logic [7:0]  placed;
	} outcome_t;

	typedef struct {
		request_t rq;
		bit       typed;
		outcome_t rs;
	} row_t;

	logic        clk, arst_n;
	logic        s_tvalid, s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid, m_tready;
	logic [31:0] m_tdata;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;

	grid_rectangle_allocator i_dut (.*);

	// shadow copy of the allocator state
	bit          ent_valid [ENTRIES];
	logic [15:0] ent_ident [ENTRIES];
	int          ent_corner [ENTRIES];
	int          ent_wid [ENTRIES];
	int          ent_hgt [ENTRIES];
	bit          ent_rot [ENTRIES];
	int          owner [256];
	int          next_ident;
	int          columns, rows;

	outcome_t    pending_outcomes [$];
	int          errors;
	int          cycles;
	int          idle_pct, stall_pct;

	function automatic void rebuild_owner(int skip);
		int tx, ty, ew, eh;
		for (int c = 0; c < 256; c++) owner[c] = 0;
		for (int e = 0; e < ENTRIES; e++) begin
			if (!ent_valid[e] || ent_ident[e] == skip || ent_corner[e] >= columns * rows)
				continue;
			tx = ent_corner[e] % columns;
			ty = ent_corner[e] / columns;
			ew = ent_rot[e] ? ent_hgt[e] : ent_wid[e];
			eh = ent_rot[e] ? ent_wid[e] : ent_hgt[e];
			for (int y = ty; y < ty + eh; y++)
				for (int x = tx; x < tx + ew; x++)
					if (x < columns && y < rows) owner[y * columns + x] = ent_ident[e];
		end
	endfunction

	function automatic bit placement_fits(int corner, int ew, int eh);
		int tx, ty;
		if (corner >= columns * rows || ew == 0 || eh == 0) return 0;
		tx = corner % columns;
		ty = corner / columns;
		if (tx + ew > columns || ty + eh > rows) return 0;
		for (int y = ty; y < ty + eh; y++)
			for (int x = tx; x < tx + ew; x++)
				if (owner[y * columns + x] != 0) return 0;
		return 1;
	endfunction

	function automatic int find_slot(int ident);
		if (ident == 0) return -1;
		for (int e = 0; e < ENTRIES; e++)
			if (ent_valid[e] && ent_ident[e] == ident) return e;
		return -1;
	endfunction

	function automatic int clamp_side(logic [31:0] v);
		if (v[4:0] == 0) return 1;
		if (v[4:0] > SIDE_MAX) return SIDE_MAX;
		return v[4:0];
	endfunction

	// next state and outcome of one request
	function automatic outcome_t allocate(request_t rq);
		outcome_t r;
		int slot, e, ew, eh;
		r = '0;
		r.placed = rq.corner;
		case (rq.op)
			OP_ADD: begin
				slot = -1;
				for (int k = 0; k < ENTRIES && slot < 0; k++)
					if (!ent_valid[k]) slot = k;
				rebuild_owner(0);
				if (rq.wid == 0 || rq.hgt == 0) r.status = ST_BAD_SIZE;
				else if (next_ident == 0 || next_ident >= IDENT_TOP || find_slot(next_ident) >= 0)
					r.status = ST_EXHAUSTED;
				else begin
					r.status = ST_NO_SPACE;
					if (slot >= 0)
						for (int c = 0; c < columns * rows; c++)
							if (placement_fits(c, rq.wid, rq.hgt)) begin
								ent_valid[slot] = 1;
								ent_ident[slot] = 16'(next_ident);
								ent_corner[slot] = c;
								ent_wid[slot] = rq.wid;
								ent_hgt[slot] = rq.hgt;
								ent_rot[slot] = 0;
								r.given = 16'(next_ident);
								r.placed = 8'(c);
								next_ident++;
								r.ok = 1;
								r.status = ST_OK;
								break;
							end
				end
			end
			OP_MOVE: begin
				e = find_slot(rq.ident);
				if (e < 0) r.status = ST_NOT_FOUND;
				else begin
					rebuild_owner(rq.ident);
					ew = rq.rot ? ent_hgt[e] : ent_wid[e];
					eh = rq.rot ? ent_wid[e] : ent_hgt[e];
					if (placement_fits(rq.corner, ew, eh)) begin
						ent_corner[e] = rq.corner;
						ent_rot[e] = rq.rot;
						r.ok = 1;
					end else r.status = ST_BAD_PLACE;
				end
			end
			OP_REMOVE: begin
				e = find_slot(rq.ident);
				if (e < 0) r.status = ST_NOT_FOUND;
				else begin
					ent_valid[e] = 0;
					r.ok = 1;
				end
			end
			default: begin
				if (rq.wid == 0 || rq.hgt == 0) r.status = ST_BAD_SIZE;
				else begin
					rebuild_owner(rq.ident);
					if (placement_fits(rq.corner, rq.rot ? rq.hgt : rq.wid,
							rq.rot ? rq.wid : rq.hgt)) r.ok = 1;
					else r.status = ST_BAD_PLACE;
				end
			end
		endcase
		rebuild_owner(0);
		return r;
	endfunction

	// clock and timeout
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	// result checking
	always @(posedge clk) begin
		outcome_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.ok = m_tdata[0];
			got.status = m_tdata[3:1];
			got.given = m_tdata[19:4];
			got.placed = m_tdata[27:20];
			if (pending_outcomes.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
			end else begin
				want = pending_outcomes.pop_front();
				if (got.ok !== want.ok || got.status !== want.status ||
						got.given !== want.given || got.placed !== want.placed) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch: exp ok %0d st %0d id %0d at %0d,",
							" got ok %0d st %0d id %0d at %0d"},
							want.ok, want.status, want.given, want.placed,
							got.ok, got.status, got.given, got.placed);
				end
			end
		end
	end

	// one request transaction, called and returning at a falling edge
	task automatic send_request(request_t rq, bit typed, outcome_t typed_rs);
		outcome_t r;
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 0;
			do @(negedge clk); while ($urandom_range(99) < idle_pct);
		end
		s_tvalid <= 1;
		s_tuser <= rq.op;
		s_tdata <= {5'b0, rq.rot, rq.corner, rq.hgt, rq.wid, rq.ident};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = allocate(rq);
		pending_outcomes.push_back(typed ? typed_rs : r);
		@(negedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 0;
		while (pending_outcomes.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	// register write then read-back
	task automatic write_register(logic idx, logic [31:0] value);
		int want;
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
		@(negedge clk) penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		want = clamp_side(value);
		if (idx == REG_COLUMNS) columns = want;
		else rows = want;
		rebuild_owner(0);
		@(negedge clk) begin psel <= 1; penable <= 0; pwrite <= 0; end
		@(negedge clk) penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want) begin
			errors++;
			if (errors <= 10) $display("register %0d: exp %0d got %0d", idx, want, prdata);
		end
		@(negedge clk) begin psel <= 0; penable <= 0; end
	endtask

	function automatic logic [15:0] pick_ident();
		logic [15:0] live [$];
		for (int e = 0; e < ENTRIES; e++) if (ent_valid[e]) live.push_back(ent_ident[e]);
		if (live.size() > 0 && $urandom_range(99) < 75)
			return live[$urandom_range(live.size() - 1)];
		return 16'($urandom);
	endfunction

	function automatic logic [4:0] pick_side();
		int k;
		k = $urandom_range(99);
		if (k < 5) return '0;
		if (k < 12) return 5'($urandom_range(16));
		return 5'($urandom_range(1, 4));
	endfunction

	function automatic request_t random_request();
		request_t rq;
		int k;
		k = $urandom_range(99);
		rq.op = k < 40 ? OP_ADD : k < 65 ? OP_MOVE : k < 80 ? OP_REMOVE : OP_CHECK;
		rq.ident = (rq.op == OP_MOVE || rq.op == OP_REMOVE || $urandom_range(1)) ?
			pick_ident() : 16'($urandom);
		rq.wid = pick_side();
		rq.hgt = pick_side();
		rq.corner = $urandom_range(99) < 85 ? 8'($urandom_range(columns * rows - 1))
			: 8'($urandom_range(255));
		rq.rot = 1'($urandom_range(1));
		return rq;
	endfunction

	row_t directed [$];
	int   grid_cols [6] = '{16, 1, 0, 5, 16, 31};
	int   grid_rows [6] = '{16, 1, 31, 12, 3, 0};

	task automatic add_row(logic [1:0] op, int ident, int w, int h, int corner, bit rot,
			bit typed, bit ok = 0, logic [2:0] st = ST_OK, int given = 0, int placed = 0);
		row_t r;
		r.rq = '{op, ident[15:0], w[4:0], h[4:0], corner[7:0], rot};
		r.typed = typed;
		r.rs = '{ok, st, given[15:0], placed[7:0]};
		directed.push_back(r);
	endtask

	initial begin
		outcome_t none;
		none = '0;
		errors = 0; cycles = 0; idle_pct = 0; stall_pct = 0;
		s_tvalid = 0; s_tdata = '0; s_tuser = '0; m_tready = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		for (int e = 0; e < ENTRIES; e++) begin
			ent_valid[e] = 0; ent_ident[e] = 0; ent_corner[e] = 0;
			ent_wid[e] = 0; ent_hgt[e] = 0; ent_rot[e] = 0;
		end
		next_ident = 1; columns = SIDE_RESET; rows = SIDE_RESET;
		rebuild_owner(0);

		// directed rows, expected values typed where obvious
		add_row(OP_ADD, 0, 1, 1, 77, 0, 1, 1, ST_OK, 1, 0);
		add_row(OP_ADD, 0, 0, 3, 9, 0, 1, 0, ST_BAD_SIZE, 0, 9);
		add_row(OP_CHECK, 0, 2, 0, 200, 1, 1, 0, ST_BAD_SIZE, 0, 200);
		add_row(OP_ADD, 65535, 16, 16, 255, 1, 1, 0, ST_NO_SPACE, 0, 255);
		add_row(OP_MOVE, 0, 1, 1, 5, 0, 1, 0, ST_NOT_FOUND, 0, 5);
		add_row(OP_REMOVE, 999, 1, 1, 0, 0, 1, 0, ST_NOT_FOUND, 0, 0);
		add_row(OP_CHECK, 0, 1, 1, 255, 0, 1, 0, ST_BAD_PLACE, 0, 255);
		add_row(OP_CHECK, 0, 1, 1, 0, 0, 1, 0, ST_BAD_PLACE, 0, 0);
		add_row(OP_CHECK, 1, 1, 1, 0, 0, 1, 1, ST_OK, 0, 0);
		add_row(OP_ADD, 0, 3, 2, 0, 0, 0);
		add_row(OP_ADD, 0, 8, 1, 0, 0, 0);
		add_row(OP_MOVE, 2, 0, 0, 60, 1, 0);
		add_row(OP_MOVE, 2, 0, 0, 62, 0, 0);
		add_row(OP_MOVE, 2, 0, 0, 62, 1, 0);
		add_row(OP_CHECK, 3, 8, 1, 8, 0, 0);
		add_row(OP_CHECK, 0, 16, 16, 0, 1, 0);
		add_row(OP_CHECK, 0, 8, 8, 0, 0, 0);
		add_row(OP_REMOVE, 1, 0, 0, 0, 0, 0);
		add_row(OP_REMOVE, 1, 0, 0, 0, 0, 0);
		add_row(OP_ADD, 0, 31, 1, 0, 0, 0);
		add_row(OP_ADD, 0, 2, 31, 0, 0, 0);
		add_row(OP_MOVE, 3, 0, 0, 8, 0, 0);

		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1;
		@(negedge clk);

		foreach (directed[i])
			send_request(directed[i].rq, directed[i].typed, directed[i].typed ? directed[i].rs : none);
		drain();

		// random phases, each under a new grid and one of four idling patterns
		for (int p = 0; p < 6; p++) begin
			write_register(REG_COLUMNS, grid_cols[p]);
			write_register(REG_ROWS, grid_rows[p]);
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 62; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 62; end
				default: begin idle_pct = 21; stall_pct = 21; end
			endcase
			repeat (180) send_request(random_request(), 0, none);
			drain();
		end

		if (errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule
